/* sv/uniform_bin_histogram_top_assert.svh */
// Assertion macros for the uniform bin histogram checker
`ifndef UNIFORM_BIN_HISTOGRAM_TOP_ASSERT_SVH
`define UNIFORM_BIN_HISTOGRAM_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define UBH_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("histogram check failed");

// next-cycle implication, off while in reset
`define UBH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("histogram check failed");

// next-cycle implication, checked during reset too
`define UBH_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("histogram reset check failed");

`endif

/* sv/ubh_pkg.sv */
// Shared types and constants of the uniform bin histogram
`default_nettype none

package ubh_pkg;

    localparam int MAX_BINS     = 256;
    localparam int COUNT_W      = 32;
    localparam int BIN_W        = $clog2(MAX_BINS);
    localparam int DATA_W       = 32;
    localparam int BINS_CFG_W   = 9;
    localparam int BNUM_W       = 8;
    localparam int PROD_W       = 64;
    localparam int IDX_W        = PROD_W - 16;
    localparam int DEFAULT_BINS = 200;
    localparam logic [PROD_W-1:0] HALF_Q16 = PROD_W'(32'h0000_8000);

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;
    localparam int CFG_ADDR_W = 2;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_READ   = 2'd1,
        KIND_ADD    = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RANGE_LOW  = 2'd0,
        CFG_RANGE_HIGH = 2'd1,
        CFG_BINS       = 2'd2,
        CFG_SCALE      = 2'd3
    } t_cfg_addr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_MULT,
        ST_INDEX,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic range_en;
        logic mult_en;
        logic index_en;
        logic read_en;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic in_sample;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

/* sv/ubh_ram.sv */
// Generic single-port-write, registered-read RAM
`default_nettype none

module ubh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/ubh_ctrl.sv */
// Sequencer of the uniform bin histogram
`default_nettype none

module ubh_ctrl import ubh_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_sample ? ST_RANGE : ST_READ;
                end
            end
            ST_RANGE: begin
                o_cmd.range_en = 1'b1;
                n_state        = ST_MULT;
            end
            ST_MULT: begin
                o_cmd.mult_en = 1'b1;
                n_state       = ST_INDEX;
            end
            ST_INDEX: begin
                o_cmd.index_en = 1'b1;
                n_state        = ST_READ;
            end
            ST_READ: begin
                o_cmd.read_en = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

/* sv/ubh_datapath.sv */
// Datapath of the uniform bin histogram: registers, binning math, counter store
`default_nettype none

module ubh_datapath import ubh_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [DATA_W-1:0]     i_cfg_wdata,
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic [1:0]            i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [M_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                       o_m_axis_tuser,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts
);

    logic signed [DATA_W-1:0]     r_range_low;
    logic signed [DATA_W-1:0]     r_range_high;
    logic        [BINS_CFG_W-1:0] r_bins_in_use;
    logic        [DATA_W-1:0]     r_bin_scale;

    t_kind                    r_kind;
    logic signed [DATA_W-1:0] r_sample;
    logic        [BNUM_W-1:0] r_bin_number;
    logic        [DATA_W-1:0] r_amount;

    logic              r_in_range;
    logic [DATA_W-1:0] r_diff;
    logic [PROD_W-1:0] r_prod;
    logic [BIN_W-1:0]  r_addr;
    logic [MAX_BINS-1:0] r_valid;
    logic              r_hit_valid;

    logic              r_out_valid;
    logic              r_out_counted;
    logic [BNUM_W-1:0] r_out_hit;
    logic [DATA_W-1:0] r_out_value;

    logic signed [DATA_W-1:0] w_lo;
    logic signed [DATA_W-1:0] w_hi;
    logic [PROD_W-1:0]  w_round;
    logic [IDX_W-1:0]   w_idx;
    logic [31:0]        w_active;
    logic [BIN_W-1:0]   w_last;
    logic [COUNT_W-1:0] w_rdata;
    logic [COUNT_W-1:0] w_base;
    logic [COUNT_W-1:0] w_inc;
    logic [COUNT_W-1:0] w_new;
    logic               w_in_store;
    logic               w_we;
    logic               w_counted;
    logic [BNUM_W-1:0]  w_hit;
    logic [DATA_W-1:0]  w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low   <= '0;
            r_range_high  <= '0;
            r_bins_in_use <= BINS_CFG_W'(DEFAULT_BINS);
            r_bin_scale   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_RANGE_LOW:  r_range_low   <= $signed(i_cfg_wdata);
                CFG_RANGE_HIGH: r_range_high  <= $signed(i_cfg_wdata);
                CFG_BINS:       r_bins_in_use <= i_cfg_wdata[BINS_CFG_W-1:0];
                CFG_SCALE:      r_bin_scale   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_sts.in_sample = (t_kind'(i_s_axis_tuser) == KIND_SAMPLE);
    assign o_sts.out_free  = !r_out_valid || i_m_axis_tready;

    assign w_lo = (r_range_low < r_range_high) ? r_range_low : r_range_high;
    assign w_hi = (r_range_low < r_range_high) ? r_range_high : r_range_low;

    assign w_round = r_prod + HALF_Q16;
    assign w_idx   = w_round[PROD_W-1:16];

    always_comb begin
        w_active = (r_bins_in_use == '0) ? 32'(DEFAULT_BINS) : 32'(r_bins_in_use);
        if (w_active > 32'(MAX_BINS)) begin
            w_active = 32'(MAX_BINS);
        end
    end
    assign w_last = BIN_W'(w_active - 32'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind       <= t_kind'(i_s_axis_tuser);
            r_sample     <= $signed(i_s_axis_tdata[31:0]);
            r_bin_number <= i_s_axis_tdata[39:32];
            r_amount     <= i_s_axis_tdata[71:40];
            r_addr       <= BIN_W'(i_s_axis_tdata[39:32]);
        end
        if (i_cmd.range_en) begin
            r_in_range <= (r_sample >= w_lo) && (r_sample <= w_hi);
            r_diff     <= unsigned'(r_sample - w_lo);
        end
        if (i_cmd.mult_en) begin
            r_prod <= PROD_W'(r_diff) * PROD_W'(r_bin_scale);
        end
        if (i_cmd.index_en) begin
            r_addr <= (w_idx > IDX_W'(w_last)) ? w_last : BIN_W'(w_idx);
        end
        if (i_cmd.read_en) begin
            r_hit_valid <= r_valid[r_addr];
        end
    end

    assign w_in_store = (32'(r_bin_number) < 32'(MAX_BINS));
    assign w_base     = r_hit_valid ? w_rdata : '0;
    assign w_inc      = (r_kind == KIND_SAMPLE) ? COUNT_W'(1) : COUNT_W'(r_amount);
    assign w_new      = w_base + w_inc;

    always_comb begin
        w_we      = 1'b0;
        w_counted = 1'b0;
        w_hit     = '0;
        w_value   = '0;
        case (r_kind)
            KIND_SAMPLE: begin
                if (r_in_range) begin
                    w_we      = 1'b1;
                    w_counted = 1'b1;
                    w_hit     = BNUM_W'(r_addr);
                    w_value   = DATA_W'(w_new);
                end
            end
            KIND_READ: begin
                w_hit = r_bin_number;
                if (w_in_store) begin
                    w_value = DATA_W'(w_base);
                end
            end
            KIND_ADD: begin
                w_hit = r_bin_number;
                if (w_in_store) begin
                    w_we    = 1'b1;
                    w_value = DATA_W'(w_new);
                end
            end
            default: begin
            end
        endcase
    end

    ubh_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(MAX_BINS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.finish && w_we),
        .i_waddr(r_addr),
        .i_wdata(w_new),
        .i_re   (i_cmd.read_en),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.finish && (r_kind == KIND_CLEAR)) begin
            r_valid <= '0;
        end else if (i_cmd.finish && w_we) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_counted <= w_counted;
            r_out_hit     <= w_hit;
            r_out_value   <= w_value;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_value, r_out_hit};
    assign o_m_axis_tuser  = r_out_counted;

endmodule

`default_nettype wire

/* sv/uniform_bin_histogram_top.sv */
// Top level of the uniform bin histogram
//
// Input channel (s_axis): one item per handshake. tuser carries the kind:
// sample, read bin, add amount to bin, clear all bins. tdata carries the
// sample, the bin number and the amount.
// Output channel (m_axis): exactly one result item per input item, in order.
// tuser is the counted flag, tdata holds the bin number and the bin count.
// Configuration: write enable, register index and 32-bit data; range ends,
// active bin count and Q16.16 scale. Write only while the block is idle.
// Sequence: items are handled one at a time by a controller and a datapath.
// A sample item passes range check, multiply, round and clamp, counter read
// and counter update in that order; read, add and clear items go straight
// to the counter read and counter update.
// The counter store has one write port and one registered read port.
// Reset: synchronous, active low. All counters read as zero afterwards (per
// bin valid bits are cleared at once); a clear item does the same.
// Stall: a result waits in the output register; the next item is taken
// meanwhile and held in its last step until the output register frees.
`default_nettype none

module uniform_bin_histogram_top import ubh_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [DATA_W-1:0]     i_cfg_wdata,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // sample [31:0], bin_number [39:32], amount [71:40]
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // kind [1:0]
    input  wire logic [1:0]            i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // bin_hit [7:0], bin_value [39:8]
    output logic      [M_TDATA_W-1:0]  o_m_axis_tdata,
    // counted [0]
    output logic                       o_m_axis_tuser
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ubh_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    ubh_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts)
    );

endmodule

`default_nettype wire

/* sv/ubh_checker.sv */
// Port-level checker of the uniform bin histogram, bound to the top level
`default_nettype none

`include "uniform_bin_histogram_top_assert.svh"

module ubh_checker import ubh_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_axis_tvalid,
    input wire logic                 o_s_axis_tready,
    input wire logic                 o_m_axis_tvalid,
    input wire logic                 i_m_axis_tready,
    input wire logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                 o_m_axis_tuser
);

    logic                 w_in_acc;
    logic                 w_in_wait;
    logic                 w_out_stall;
    logic [M_TDATA_W+1:0] w_out_bus;

    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_wait   = o_s_axis_tready && !i_s_axis_tvalid;
    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_out_bus   = {o_m_axis_tvalid, o_m_axis_tuser, o_m_axis_tdata};

    `UBH_ASSERT_NEXT(a_out_hold, w_out_stall, $stable(w_out_bus))
    `UBH_ASSERT_NEXT(a_busy_after_accept, w_in_acc, !o_s_axis_tready)
    `UBH_ASSERT_IMPL(a_min_latency, $rose(o_m_axis_tvalid), !$past(w_in_acc) && !$past(w_in_acc, 2))
    `UBH_ASSERT_RESET(a_reset_idle, !i_rst_n, !o_m_axis_tvalid && o_s_axis_tready)
    `UBH_ASSERT_NEXT(a_ready_while_idle, w_in_wait, o_s_axis_tready)

endmodule

bind uniform_bin_histogram_top ubh_checker u_checker (.*);

`default_nettype wire
